// File: sv/lfu_pkg.sv
package lfu_pkg;

	localparam int DATA_W = 32;
	localparam int CAP_W  = 5;

	localparam logic OP_GET = 1'b0;
	localparam logic OP_PUT = 1'b1;

	localparam logic [DATA_W-1:0] MISS_VALUE  = '1;
	localparam logic [DATA_W-1:0] COUNT_MAX   = '1;
	localparam logic [DATA_W-1:0] COUNT_FIRST = DATA_W'(1);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_LAST,
		ST_WRITE
	} state_t;

	typedef struct packed {
		logic              valid;
		logic [DATA_W-1:0] key;
		logic [DATA_W-1:0] value;
		logic [DATA_W-1:0] count;
		logic [DATA_W-1:0] stamp;
	} row_t;

	typedef struct packed {
		logic hit;
		logic free_ok;
		logic vic_ok;
	} scan_flags_t;

	function automatic logic [DATA_W-1:0] sat_inc(input logic [DATA_W-1:0] c);
		logic [DATA_W-1:0] r;
		r = (c == COUNT_MAX) ? c : c + DATA_W'(1);
		return r;
	endfunction

endpackage

// File: sv/lfu_ram.sv
module lfu_ram
	import lfu_pkg::*;
#(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  row_t          wdata,
	input  logic [AW-1:0] raddr,
	output row_t          rdata
);

	row_t mem_q [DEPTH];
	row_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: sv/lfu_scan.sv
module lfu_scan
	import lfu_pkg::*;
#(
	parameter int AW = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              clr,
	input  logic              sample,
	input  row_t              row,
	input  logic [AW-1:0]     row_idx,
	input  logic [DATA_W-1:0] key,
	output scan_flags_t       flags,
	output logic [AW-1:0]     hit_idx,
	output logic [DATA_W-1:0] hit_value,
	output logic [DATA_W-1:0] hit_count,
	output logic [AW-1:0]     free_idx,
	output logic [AW-1:0]     vic_idx
);

	scan_flags_t       flags_q;
	logic [AW-1:0]     hit_idx_q;
	logic [DATA_W-1:0] hit_value_q;
	logic [DATA_W-1:0] hit_count_q;
	logic [AW-1:0]     free_idx_q;
	logic [AW-1:0]     vic_idx_q;
	logic [DATA_W-1:0] vic_count_q;
	logic [DATA_W-1:0] vic_stamp_q;
	logic              is_match;
	logic              is_older;

	assign is_match = row.valid && (row.key == key);
	assign is_older = {row.count, row.stamp} < {vic_count_q, vic_stamp_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
		end else if (clr) begin
			flags_q <= '0;
		end else if (sample) begin
			if (is_match) begin
				flags_q.hit <= 1'b1;
			end
			if (!row.valid) begin
				flags_q.free_ok <= 1'b1;
			end else begin
				flags_q.vic_ok <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sample) begin
			if (is_match && !flags_q.hit) begin
				hit_idx_q   <= row_idx;
				hit_value_q <= row.value;
				hit_count_q <= row.count;
			end
			if (!row.valid && !flags_q.free_ok) begin
				free_idx_q <= row_idx;
			end
			if (row.valid && (!flags_q.vic_ok || is_older)) begin
				vic_idx_q   <= row_idx;
				vic_count_q <= row.count;
				vic_stamp_q <= row.stamp;
			end
		end
	end

	assign flags     = flags_q;
	assign hit_idx   = hit_idx_q;
	assign hit_value = hit_value_q;
	assign hit_count = hit_count_q;
	assign free_idx  = free_idx_q;
	assign vic_idx   = vic_idx_q;

endmodule

// File: sv/lfu_cache_controller.sv
// An item accepted in ST_IDLE passes through ST_SCAN, ST_LAST and ST_WRITE; its result is
// registered onto m_tvalid once the output is free; only then is the next item taken. The
// scan reads one table row per cycle through the single read port of the entry memory.
// Reset: arst_n clears control state and then a clearing pass over every row marks it
// empty; s_tready stays low during that pass.
module lfu_cache_controller
	import lfu_pkg::*;
#(
	parameter int ENTRIES = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CAP_W-1:0]  cfg_wdata,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [63:0]       s_tdata,   // key [31:0], write_value [63:32]
	input  logic              s_tuser,   // operation
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [DATA_W-1:0] m_tdata,   // read_value [31:0]
	output logic              m_tuser    // found
);

	localparam int AW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int OCC_W = $clog2(ENTRIES + 1);
	localparam int CW    = (OCC_W > CAP_W) ? OCC_W : CAP_W;

	state_t            state_q, state_d;
	logic [AW-1:0]     idx_q;
	logic              rvalid_s1;
	logic [AW-1:0]     ridx_s1;
	logic [CAP_W-1:0]  capacity_q;
	logic [OCC_W-1:0]  occ_q;
	logic [DATA_W-1:0] stamp_q;
	logic              op_q;
	logic [DATA_W-1:0] key_q;
	logic [DATA_W-1:0] wval_q;
	logic              m_tvalid_q;
	logic              m_tuser_q;
	logic [DATA_W-1:0] m_tdata_q;

	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	row_t              ram_wdata;
	row_t              ram_rdata;
	logic [AW-1:0]     ram_raddr;
	logic              accept;
	logic              idx_last;
	logic              out_load;
	logic              out_found;
	logic [DATA_W-1:0] out_value;
	logic              occ_inc;
	logic              stamp_inc;
	logic [CW-1:0]     cap_eff;

	scan_flags_t       flags;
	logic [AW-1:0]     hit_idx;
	logic [DATA_W-1:0] hit_value;
	logic [DATA_W-1:0] hit_count;
	logic [AW-1:0]     free_idx;
	logic [AW-1:0]     vic_idx;

	assign accept   = s_tvalid && s_tready;
	assign idx_last = (idx_q == AW'(ENTRIES - 1));
	assign cap_eff  = (CW'(capacity_q) > CW'(ENTRIES)) ? CW'(ENTRIES) : CW'(capacity_q);

	lfu_ram #(
		.DEPTH (ENTRIES),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	lfu_scan #(
		.AW (AW)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.clr       (accept),
		.sample    (rvalid_s1),
		.row       (ram_rdata),
		.row_idx   (ridx_s1),
		.key       (key_q),
		.flags     (flags),
		.hit_idx   (hit_idx),
		.hit_value (hit_value),
		.hit_count (hit_count),
		.free_idx  (free_idx),
		.vic_idx   (vic_idx)
	);

	always_comb begin
		state_d   = state_q;
		s_tready  = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = '0;
		ram_raddr = idx_q;
		out_load  = 1'b0;
		out_found = flags.hit;
		out_value = '0;
		occ_inc   = 1'b0;
		stamp_inc = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				ram_we = 1'b1;
				if (idx_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (idx_last) begin
					state_d = ST_LAST;
				end
			end
			ST_LAST: begin
				state_d = ST_WRITE;
			end
			ST_WRITE: begin
				if (!m_tvalid_q || m_tready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
					if (op_q == OP_GET) begin
						if (flags.hit) begin
							out_value = hit_value;
							ram_we    = 1'b1;
							ram_waddr = hit_idx;
							ram_wdata = '{valid: 1'b1, key: key_q, value: hit_value,
								count: sat_inc(hit_count), stamp: stamp_q};
						end else begin
							out_value = MISS_VALUE;
						end
					end else if (flags.hit) begin
						ram_we    = 1'b1;
						ram_waddr = hit_idx;
						ram_wdata = '{valid: 1'b1, key: key_q, value: wval_q,
							count: sat_inc(hit_count), stamp: stamp_q};
					end else if (cap_eff != '0) begin
						ram_wdata = '{valid: 1'b1, key: key_q, value: wval_q,
							count: COUNT_FIRST, stamp: stamp_q};
						if ((CW'(occ_q) < cap_eff) && flags.free_ok) begin
							ram_we    = 1'b1;
							ram_waddr = free_idx;
							occ_inc   = 1'b1;
						end else if (flags.vic_ok) begin
							ram_we    = 1'b1;
							ram_waddr = vic_idx;
						end else if (flags.free_ok) begin
							ram_we    = 1'b1;
							ram_waddr = free_idx;
							occ_inc   = 1'b1;
						end
					end
					stamp_inc = ram_we;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			idx_q      <= '0;
			rvalid_s1  <= 1'b0;
			capacity_q <= CAP_W'(16);
			occ_q      <= '0;
			stamp_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			rvalid_s1 <= (state_q == ST_SCAN);
			if (state_q == ST_CLEAR || state_q == ST_SCAN) begin
				idx_q <= idx_last ? '0 : idx_q + AW'(1);
			end
			if (cfg_we) begin
				capacity_q <= cfg_wdata;
			end
			if (occ_inc) begin
				occ_q <= occ_q + OCC_W'(1);
			end
			if (stamp_inc) begin
				stamp_q <= stamp_q + DATA_W'(1);
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		ridx_s1 <= idx_q;
		if (accept) begin
			op_q   <= s_tuser;
			key_q  <= s_tdata[31:0];
			wval_q <= s_tdata[63:32];
		end
		if (out_load) begin
			m_tuser_q <= out_found;
			m_tdata_q <= out_value;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = m_tuser_q;
	assign m_tdata  = m_tdata_q;

endmodule

// File: sv/lfu_checker.sv
module lfu_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic        m_tuser,
	input logic [31:0] m_tdata
);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input taken again right after an item");

	a_result_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("result appeared without a finished item");

	a_miss_value: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser) |-> (m_tdata == 32'hFFFF_FFFF || m_tdata == 32'h0))
		else $error("miss result carries a stored value");

	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
		else $error("stalled result changed");

endmodule

bind lfu_cache_controller lfu_checker u_lfu_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tuser  (m_tuser),
	.m_tdata  (m_tdata)
);
